/* hdl/assert_macros.svh */
// Assertion macros shared by the dispenser frame encoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_RST(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a boolean condition never holds outside reset.
`define ASSERT_NEVER(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* hdl/dfe_pkg.sv */
// Types, codes and helper functions of the dispenser frame encoder.
// Depends on nothing; imported by every module of the block.
package dfe_pkg;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_PUMP    = 3'd1,
    ERR_COMMAND = 3'd2,
    ERR_PRICE   = 3'd3,
    ERR_VOLUME  = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0]  pump_number;
    logic [7:0]  command_code;
    logic [19:0] price_value;
    logic [19:0] volume_value;
    logic [15:0] status_word;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [2:0] error_code;
    logic       last_of_frame;
  } res_t;

  typedef struct packed {
    err_e        err;
    logic [7:0]  pump;
    logic [3:0]  cmd;
    logic [19:0] price;
    logic [19:0] volume;
    logic [15:0] status;
  } job_t;

  localparam logic [7:0]  PUMP_MAX    = 8'd128;
  localparam logic [7:0]  COMMAND_MAX = 8'd15;
  localparam logic [19:0] DEC_MAX     = 20'd999999;

  localparam logic [7:0] CHAR_SOH  = 8'h01;
  localparam logic [7:0] CHAR_STX  = 8'h02;
  localparam logic [7:0] CHAR_ETX  = 8'h03;
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_HEXA = 8'h37;

  localparam int unsigned IDX_W = 5;

  localparam logic [IDX_W-1:0] POS_SOH     = 5'd0;
  localparam logic [IDX_W-1:0] POS_PUMP_HI = 5'd1;
  localparam logic [IDX_W-1:0] POS_PUMP_LO = 5'd2;
  localparam logic [IDX_W-1:0] POS_CMD     = 5'd3;
  localparam logic [IDX_W-1:0] POS_STX     = 5'd4;
  localparam logic [IDX_W-1:0] POS_PRICE   = 5'd5;
  localparam logic [IDX_W-1:0] POS_VOLUME  = 5'd11;
  localparam logic [IDX_W-1:0] POS_STAT3   = 5'd17;
  localparam logic [IDX_W-1:0] POS_STAT2   = 5'd18;
  localparam logic [IDX_W-1:0] POS_STAT1   = 5'd19;
  localparam logic [IDX_W-1:0] POS_STAT0   = 5'd20;
  localparam logic [IDX_W-1:0] POS_ETX     = 5'd21;
  localparam logic [IDX_W-1:0] POS_CHECK   = 5'd22;
  localparam logic [IDX_W-1:0] POS_LAST    = 5'd23;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] base;
    base = (nib > 4'd9) ? CHAR_HEXA : CHAR_ZERO;
    return base + {4'd0, nib};
  endfunction

  function automatic logic [19:0] dec_weight(input logic [2:0] place);
    logic [19:0] w;
    case (place)
      3'd0:    w = 20'd100000;
      3'd1:    w = 20'd10000;
      3'd2:    w = 20'd1000;
      3'd3:    w = 20'd100;
      3'd4:    w = 20'd10;
      default: w = 20'd1;
    endcase
    return w;
  endfunction

endpackage

/* hdl/dfe_front.sv */
// Front end: accepts requests and classifies them into jobs.
// Depends on dfe_pkg; feeds dfe_queue.
module dfe_front import dfe_pkg::*; (
  input  logic push,
  input  req_t req_i,
  output logic full,
  input  logic q_full_i,
  output logic job_push_o,
  output job_t job_o
);

  err_e err;

  always_comb begin
    if (req_i.pump_number > PUMP_MAX) begin
      err = ERR_PUMP;
    end else if (req_i.command_code > COMMAND_MAX) begin
      err = ERR_COMMAND;
    end else if (req_i.price_value > DEC_MAX) begin
      err = ERR_PRICE;
    end else if (req_i.volume_value > DEC_MAX) begin
      err = ERR_VOLUME;
    end else begin
      err = ERR_NONE;
    end
  end

  always_comb begin
    job_o.err    = err;
    job_o.pump   = req_i.pump_number;
    job_o.cmd    = req_i.command_code[3:0];
    job_o.price  = req_i.price_value;
    job_o.volume = req_i.volume_value;
    job_o.status = req_i.status_word;
  end

  assign full       = q_full_i;
  assign job_push_o = push && !q_full_i;

endmodule

/* hdl/dfe_queue.sv */
// Short job queue between front end and frame generator.
// Depends on dfe_pkg and assert_macros.svh.
module dfe_queue import dfe_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic valid_o
);

  `include "assert_macros.svh"

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(DEPTH), "queue overfilled")
  `ASSERT_NEVER(a_ptr_range, clk_i, rst_ni, (wr_ptr_q > PTR_LAST) || (rd_ptr_q > PTR_LAST), "pointer out of range")

endmodule

/* hdl/dfe_back.sv */
// Frame generator: expands one job into frame words or one error word.
// Depends on dfe_pkg and assert_macros.svh; fed by dfe_queue.
module dfe_back import dfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t job_i,
  input  logic job_valid_i,
  output logic job_pop_o,
  output logic empty,
  input  logic pop,
  output res_t res_o
);

  `include "assert_macros.svh"

  logic             active_q;
  logic [IDX_W-1:0] idx_q;
  job_t             job_q;
  logic [19:0]      price_q, price_d;
  logic [19:0]      vol_q, vol_d;
  logic [7:0]       chk_q;
  res_t             out_q;
  logic             out_valid_q;

  logic        advance, emit, is_err, is_last, load;
  logic        in_price, in_volume;
  logic [19:0] dig_val, weight, dig_sub, dig_rem;
  logic [2:0]  place;
  logic [8:0]  ge;
  logic [3:0]  digit;
  logic [7:0]  byte_d;
  res_t        res_d;

  assign advance   = !out_valid_q || pop;
  assign emit      = active_q && advance;
  assign is_err    = (job_q.err != ERR_NONE);
  assign is_last   = is_err || (idx_q == POS_LAST);
  assign load      = job_valid_i && (!active_q || (emit && is_last));
  assign job_pop_o = load;

  assign in_price  = (idx_q >= POS_PRICE) && (idx_q < POS_VOLUME);
  assign in_volume = (idx_q >= POS_VOLUME) && (idx_q < POS_STAT3);

  // one decimal digit per word, most significant first
  always_comb begin
    dig_val = in_price ? price_q : vol_q;
    place   = in_price ? 3'(idx_q - POS_PRICE) : 3'(idx_q - POS_VOLUME);
    weight  = dec_weight(place);
    digit   = '0;
    for (int k = 1; k <= 9; k++) begin
      ge[k-1] = (dig_val >= 20'(k) * weight);
    end
    for (int k = 0; k < 9; k++) begin
      digit = digit + {3'd0, ge[k]};
    end
    dig_sub = 20'(digit) * weight;
    dig_rem = dig_val - dig_sub;
  end

  always_comb begin
    case (idx_q)
      POS_SOH:     byte_d = CHAR_SOH;
      POS_PUMP_HI: byte_d = hex_char(job_q.pump[7:4]);
      POS_PUMP_LO: byte_d = hex_char(job_q.pump[3:0]);
      POS_CMD:     byte_d = hex_char(job_q.cmd);
      POS_STX:     byte_d = CHAR_STX;
      POS_STAT3:   byte_d = hex_char(job_q.status[15:12]);
      POS_STAT2:   byte_d = hex_char(job_q.status[11:8]);
      POS_STAT1:   byte_d = hex_char(job_q.status[7:4]);
      POS_STAT0:   byte_d = hex_char(job_q.status[3:0]);
      POS_ETX:     byte_d = CHAR_ETX;
      POS_CHECK:   byte_d = chk_q;
      POS_LAST:    byte_d = CHAR_NUL;
      default:     byte_d = (in_price || in_volume) ? CHAR_ZERO + {4'd0, digit} : CHAR_NUL;
    endcase
  end

  always_comb begin
    res_d.frame_byte    = is_err ? CHAR_NUL : byte_d;
    res_d.error_code    = job_q.err;
    res_d.last_of_frame = is_last;
    price_d             = (emit && in_price) ? dig_rem : price_q;
    vol_d               = (emit && in_volume) ? dig_rem : vol_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        active_q <= 1'b1;
        idx_q    <= POS_SOH;
      end else if (emit && is_last) begin
        active_q <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q   <= job_i;
      price_q <= job_i.price;
      vol_q   <= job_i.volume;
      chk_q   <= '0;
    end else begin
      price_q <= price_d;
      vol_q   <= vol_d;
      if (emit && (idx_q >= POS_PUMP_HI) && (idx_q <= POS_ETX)) begin
        chk_q <= chk_q ^ byte_d;
      end
    end
    if (emit) begin
      out_q <= res_d;
    end
  end

  assign empty = !out_valid_q;
  assign res_o = out_q;

  `ASSERT_RST(a_err_word, clk_i, rst_ni, out_valid_q && (out_q.error_code != ERR_NONE) |-> (out_q.frame_byte == CHAR_NUL) && out_q.last_of_frame, "malformed error word")
  `ASSERT_NEVER(a_idx_range, clk_i, rst_ni, active_q && (idx_q > POS_LAST), "frame index beyond last word")
  `ASSERT_RST(a_err_single, clk_i, rst_ni, active_q && is_err |-> (idx_q == POS_SOH), "error job advanced past first word")

endmodule

/* hdl/dispenser_frame_encoder_top.sv */
// Top level of the dispenser frame encoder.
// Depends on dfe_pkg, dfe_front, dfe_queue and dfe_back.
//
// Each request yields either one error word or a 24-word ASCII frame, one
// word per cycle while the output side keeps popping; the single frame
// generator starts the next frame directly after the last word of the
// previous one. A request arriving at an idle block is first loaded into
// the generator. Up to QUEUE_DEPTH classified requests wait between the
// input side and the generator, and one finished word is held in the
// output register, so each side stalls on its own.
module dispenser_frame_encoder_top import dfe_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  req_t req_i,
  output logic empty,
  input  logic pop,
  output res_t res_o
);

  job_t front_job;
  logic front_push;
  logic q_full;
  job_t q_job;
  logic q_valid;
  logic q_pop;

  dfe_front u_front (
    .push       (push),
    .req_i      (req_i),
    .full       (full),
    .q_full_i   (q_full),
    .job_push_o (front_push),
    .job_o      (front_job)
  );

  dfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_job),
    .valid_o (q_valid)
  );

  dfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_job),
    .job_valid_i (q_valid),
    .job_pop_o   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o)
  );

endmodule

/* bench/dfe_frame_checker.sv */
// Scoreboard for the dispenser frame encoder: predicts the words of each request.
// Watches both queue sides and compares every popped word with the oldest prediction.
// Depends on dfe_pkg for the request, result and error types.
module dfe_frame_checker import dfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic full_i,
  input  req_t req_i,
  input  logic empty_i,
  input  logic pop_i,
  input  res_t res_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   requests_o,
  output int   rejects_o,
  output int   words_o
);
  timeunit 1ns;
  timeprecision 1ps;

  res_t expected_words[$];
  res_t want;
  int   fails = 0;
  int   pending = 0;
  int   requests = 0;
  int   rejects = 0;
  int   words = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign requests_o   = requests;
  assign rejects_o    = rejects;
  assign words_o      = words;

  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    return (nib > 4'd9) ? ("A" - 8'd10 + {4'd0, nib}) : ("0" + {4'd0, nib});
  endfunction

  function automatic err_e classify(input req_t r);
    if (r.pump_number > 8'd128)
      return ERR_PUMP;
    if (r.command_code > 8'd15)
      return ERR_COMMAND;
    if (r.price_value > 20'd999999)
      return ERR_PRICE;
    if (r.volume_value > 20'd999999)
      return ERR_VOLUME;
    return ERR_NONE;
  endfunction

  function automatic void predict_words(input req_t r);
    logic [7:0]  frame [24];
    logic [7:0]  check;
    logic [19:0] t;
    int          k;
    err_e        code;
    code = classify(r);
    if (code != ERR_NONE) begin
      expected_words.push_back('{frame_byte: 8'd0, error_code: code, last_of_frame: 1'b1});
      return;
    end
    frame[0] = CHAR_SOH;
    frame[1] = nibble_char(r.pump_number[7:4]);
    frame[2] = nibble_char(r.pump_number[3:0]);
    frame[3] = nibble_char(r.command_code[3:0]);
    frame[4] = CHAR_STX;
    t = r.price_value;
    for (k = 10; k >= 5; k--) begin
      frame[k] = "0" + 8'(t % 20'd10);
      t = t / 20'd10;
    end
    t = r.volume_value;
    for (k = 16; k >= 11; k--) begin
      frame[k] = "0" + 8'(t % 20'd10);
      t = t / 20'd10;
    end
    frame[17] = nibble_char(r.status_word[15:12]);
    frame[18] = nibble_char(r.status_word[11:8]);
    frame[19] = nibble_char(r.status_word[7:4]);
    frame[20] = nibble_char(r.status_word[3:0]);
    frame[21] = CHAR_ETX;
    check = 8'd0;
    for (k = 1; k <= 21; k++)
      check = check ^ frame[k];
    frame[22] = check;
    frame[23] = CHAR_NUL;
    for (k = 0; k < 24; k++)
      expected_words.push_back('{frame_byte: frame[k], error_code: ERR_NONE,
                                 last_of_frame: (k == 23)});
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_i) begin
        words++;
        if (expected_words.size() == 0) begin
          $error("unexpected word: frame_byte %0h error_code %0d last_of_frame %0b",
                 res_i.frame_byte, res_i.error_code, res_i.last_of_frame);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (res_i.frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %0h, got %0h", want.frame_byte, res_i.frame_byte);
            fails++;
          end
          if (res_i.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, res_i.error_code);
            fails++;
          end
          if (res_i.last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame: expected %0b, got %0b", want.last_of_frame,
                   res_i.last_of_frame);
            fails++;
          end
        end
      end
      if (push_i && !full_i) begin
        requests++;
        if (classify(req_i) != ERR_NONE)
          rejects++;
        predict_words(req_i);
      end
      pending = expected_words.size();
    end
  end

endmodule

/* bench/dispenser_frame_encoder_top_test.sv */
// Testbench top for the dispenser frame encoder: clock, reset, request and pop traffic.
// Directed edge cases first, then random requests with random gaps on both sides.
// Depends on dfe_pkg, dispenser_frame_encoder_top and dfe_frame_checker.
module dispenser_frame_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dfe_pkg::*;

  localparam longint TIMEOUT_NS = 64'd10_000_000;
  localparam int     RANDOM_REQUESTS = 230;
  localparam int     TAIL_CYCLES = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  req_t req_i = '0;
  logic full;
  logic empty;
  res_t res_o;

  int   fail_count;
  int   pending;
  int   requests;
  int   rejects;
  int   words;
  int   stall_left = 0;
  bit   steady_flow = 1'b0;

  always #5 clk_i = ~clk_i;

  dispenser_frame_encoder_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .req_i (req_i),
    .empty (empty),
    .pop   (pop),
    .res_o (res_o)
  );

  dfe_frame_checker frame_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .req_i       (req_i),
    .empty_i     (empty),
    .pop_i       (pop),
    .res_i       (res_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .requests_o  (requests),
    .rejects_o   (rejects),
    .words_o     (words)
  );

  function automatic int idle_length();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic req_t make_req(input logic [7:0] pump, input logic [7:0] cmd,
                                    input logic [19:0] price, input logic [19:0] volume,
                                    input logic [15:0] status);
    return '{pump_number: pump, command_code: cmd, price_value: price,
             volume_value: volume, status_word: status};
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   kind;
    kind = $urandom_range(0, 99);
    r = make_req(8'($urandom_range(0, 128)), 8'($urandom_range(0, 15)),
                 20'($urandom_range(0, 999999)), 20'($urandom_range(0, 999999)),
                 16'($urandom_range(0, 65535)));
    if (kind >= 90) begin
      r = make_req(8'($urandom), 8'($urandom), 20'($urandom), 20'($urandom),
                   16'($urandom));
    end else if (kind >= 75) begin
      case ($urandom_range(0, 3))
        0:       r.pump_number  = 8'($urandom_range(129, 255));
        1:       r.command_code = 8'($urandom_range(16, 255));
        2:       r.price_value  = 20'($urandom_range(1000000, 1048575));
        default: r.volume_value = 20'($urandom_range(1000000, 1048575));
      endcase
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int gap;
    gap = (steady_flow || $urandom_range(0, 9) < 6) ? 0 : idle_length();
    if (gap > 0) begin
      @(negedge clk_i) push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push  <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady_flow && $urandom_range(0, 4) == 0) begin
      pop <= 1'b0;
      stall_left <= idle_length() - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_request(make_req(8'd0, 8'd0, 20'd0, 20'd0, 16'h0000));
    send_request(make_req(8'd128, 8'd15, 20'd999999, 20'd999999, 16'hFFFF));
    send_request(make_req(8'h7A, 8'h0B, 20'd123456, 20'd789012, 16'h09AF));
    send_request(make_req(8'h3E, 8'h0D, 20'd987654, 20'd10203, 16'hBCDE));
    send_request(make_req(8'h80, 8'h0A, 20'd500000, 20'd500001, 16'h1234));
    send_request(make_req(8'h0F, 8'h0C, 20'd999998, 20'd1, 16'hFEDC));
    send_request(make_req(8'd100, 8'd9, 20'd90, 20'd999990, 16'h5678));
    send_request(make_req(8'd1, 8'd1, 20'd1, 20'd1, 16'h0001));
    send_request(make_req(8'd129, 8'd0, 20'd0, 20'd0, 16'h0000));
    send_request(make_req(8'd255, 8'd255, 20'hFFFFF, 20'hFFFFF, 16'hFFFF));
    send_request(make_req(8'd0, 8'd16, 20'd0, 20'd0, 16'h0000));
    send_request(make_req(8'd128, 8'd255, 20'hFFFFF, 20'hFFFFF, 16'hA5C3));
    send_request(make_req(8'd5, 8'd3, 20'd1000000, 20'd0, 16'h0000));
    send_request(make_req(8'd5, 8'd15, 20'hFFFFF, 20'hFFFFF, 16'h3C5A));
    send_request(make_req(8'd5, 8'd3, 20'd999999, 20'd1000000, 16'h0000));
    send_request(make_req(8'd0, 8'd0, 20'd0, 20'hFFFFF, 16'hFFFF));
    send_request(make_req(8'hAB, 8'd0, 20'd0, 20'd0, 16'h0000));

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 50 == 0)
        steady_flow = ($urandom_range(0, 2) == 0);
      send_request(random_request());
    end
    @(negedge clk_i) push <= 1'b0;
    steady_flow = 1'b1;

    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Sent %0d requests, %0d rejected by field checks; %0d result words checked.",
             requests, rejects, words);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
